### rtl/iie_pkg.sv
`timescale 1ns / 1ps

package iie_pkg;

  localparam int PAGE_W = 52;
  localparam int GCTX_W = 16;
  localparam int PCTX_W = 20;
  localparam int COUNT_W = 5;

  localparam logic [1:0] OP_FILL = 2'd0;
  localparam logic [1:0] OP_VMA = 2'd1;
  localparam logic [1:0] OP_GVMA = 2'd2;

  typedef struct packed {
    logic              guest_valid;
    logic [GCTX_W-1:0] guest_ctx;
    logic              proc_valid;
    logic [PCTX_W-1:0] proc_ctx;
    logic              is_global;
    logic [PAGE_W-1:0] page;
    logic              range_flag;
  } tag_t;

  typedef struct packed {
    logic [1:0]        op;
    logic [3:0]        entry_index;
    logic              guest_valid;
    logic              addr_valid;
    logic              proc_valid;
    logic [GCTX_W-1:0] guest_ctx;
    logic [PCTX_W-1:0] proc_ctx;
    logic              is_global;
    logic [PAGE_W-1:0] page;
    logic              range_flag;
  } item_t;

  // Controller to datapath strobes.
  typedef struct packed {
    logic load;
    logic fill;
    logic rd_en;
    logic out_load;
  } ctl_cmd_t;

  function automatic logic [PAGE_W-1:0] span_mask(logic [PAGE_W-1:0] page, logic rng);
    logic [PAGE_W-1:0] m;
    m = page ^ (page + PAGE_W'(1));
    return rng ? m : '0;
  endfunction

endpackage

### rtl/iie_ctrl.sv
`timescale 1ns / 1ps

module iie_ctrl #(
  parameter int ENTRIES = 16,
  parameter int IW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  output logic              out_valid,
  input  logic              out_stall,
  output iie_pkg::ctl_cmd_t cmd,
  output logic [IW-1:0]     rd_addr
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_FILL   = 5'b00010,
    S_SCAN   = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_RESULT = 5'b10000
  } state_t;

  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  state_t state, state_next;
  logic [IW-1:0] ptr, ptr_next;
  logic accept, out_free;

  assign in_stall = (state != S_IDLE);
  assign accept = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign rd_addr = ptr;

  always_comb begin
    state_next = state;
    ptr_next = ptr;
    cmd = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.load = 1'b1;
          ptr_next = '0;
          if (op == iie_pkg::OP_FILL) begin
            state_next = S_FILL;
          end else if (op == iie_pkg::OP_VMA || op == iie_pkg::OP_GVMA) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_RESULT;
          end
        end
      end
      S_FILL: begin
        cmd.fill = 1'b1;
        state_next = S_RESULT;
      end
      S_SCAN: begin
        cmd.rd_en = 1'b1;
        if (ptr == LAST) begin
          state_next = S_DRAIN;
        end else begin
          ptr_next = ptr + IW'(1);
        end
      end
      S_DRAIN: begin
        // last compare happens in the datapath this cycle
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ptr <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      ptr <= ptr_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_out_load_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || !out_stall))
    else $error("result loaded over an item still waiting");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != S_IDLE))
    else $error("accepted item did not start work");

  a_held_result: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> out_valid)
    else $error("stalled result dropped");

endmodule

### rtl/iie_datapath.sv
`timescale 1ns / 1ps

module iie_datapath #(
  parameter int ENTRIES = 16,
  parameter int IW = 4,
  parameter int CW = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  iie_pkg::item_t                item,
  input  iie_pkg::ctl_cmd_t             cmd,
  input  logic [IW-1:0]                 rd_addr,
  output logic [iie_pkg::COUNT_W-1:0]   cleared_count,
  output logic [iie_pkg::COUNT_W-1:0]   valid_count
);

  iie_pkg::item_t cur;
  logic [iie_pkg::PAGE_W-1:0] cur_span;
  iie_pkg::tag_t mem [ENTRIES];
  iie_pkg::tag_t rd_data;
  logic [ENTRIES-1:0] slot_valid;
  logic cmp_vld;
  logic [IW-1:0] cmp_addr;
  logic [CW-1:0] clr, vcnt;
  logic [IW-1:0] fill_addr;
  logic fill_ok;
  logic [iie_pkg::PAGE_W-1:0] span, diff;
  logic ovl, gctx_eq, pctx_eq, hit_vma, hit_gvma, hit;

  function automatic logic [iie_pkg::COUNT_W-1:0] sat(logic [CW-1:0] v);
    return (32'(v) > 32'd31) ? iie_pkg::COUNT_W'(31) : iie_pkg::COUNT_W'(v);
  endfunction

  assign fill_addr = IW'(cur.entry_index);
  assign fill_ok = 32'(cur.entry_index) < ENTRIES;

  // overlap of two NAPOT ranges: compare above the union of their spans
  assign span = cur_span | iie_pkg::span_mask(rd_data.page, rd_data.range_flag);
  assign diff = (cur.page ^ rd_data.page) & ~span;
  assign ovl = (diff == '0);
  assign gctx_eq = (rd_data.guest_ctx == cur.guest_ctx);
  assign pctx_eq = (rd_data.proc_ctx == cur.proc_ctx);

  assign hit_vma = (cur.guest_valid ? (rd_data.guest_valid && gctx_eq) : !rd_data.guest_valid)
                && (!cur.proc_valid || (rd_data.proc_valid && pctx_eq))
                && (!cur.proc_valid || !rd_data.is_global)
                && (!cur.addr_valid || ovl);
  assign hit_gvma = rd_data.guest_valid && (!cur.guest_valid || gctx_eq)
                 && (rd_data.proc_valid || !cur.addr_valid || !cur.guest_valid || ovl);
  assign hit = cmp_vld && slot_valid[cmp_addr]
            && ((cur.op == iie_pkg::OP_VMA) ? hit_vma : hit_gvma);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cur <= item;
      cur_span <= iie_pkg::span_mask(item.page, item.range_flag);
    end
    if (cmd.fill && fill_ok) begin
      mem[fill_addr] <= '{guest_valid: cur.guest_valid, guest_ctx: cur.guest_ctx,
                          proc_valid: cur.proc_valid, proc_ctx: cur.proc_ctx,
                          is_global: cur.is_global, page: cur.page,
                          range_flag: cur.range_flag};
    end
    if (cmd.rd_en) begin
      rd_data <= mem[rd_addr];
    end
    cmp_addr <= rd_addr;
    if (cmd.out_load) begin
      cleared_count <= sat(clr);
      valid_count <= sat(vcnt);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      cmp_vld <= 1'b0;
      clr <= '0;
      vcnt <= '0;
    end else begin
      cmp_vld <= cmd.rd_en;
      if (cmd.load) begin
        clr <= '0;
      end
      if (cmd.fill && fill_ok) begin
        slot_valid[fill_addr] <= 1'b1;
        if (!slot_valid[fill_addr]) begin
          vcnt <= vcnt + CW'(1);
        end
      end
      if (hit) begin
        slot_valid[cmp_addr] <= 1'b0;
        clr <= clr + CW'(1);
        vcnt <= vcnt - CW'(1);
      end
    end
  end

  a_vcnt_matches: assert property (@(posedge clk) disable iff (rst)
    32'(vcnt) == $countones(slot_valid))
    else $error("valid count out of step with valid bits");

  a_hit_drops: assert property (@(posedge clk) disable iff (rst)
    hit |=> !slot_valid[$past(cmp_addr)])
    else $error("matched entry still valid");

  a_clr_bound: assert property (@(posedge clk) disable iff (rst)
    32'(clr) <= ENTRIES)
    else $error("cleared count beyond table size");

endmodule

### rtl/iotlb_invalidate_engine_core.sv
`timescale 1ns / 1ps
// channel  | handshake            | payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_stall  | op, entry_index, guest_valid, addr_valid,
//          |                      | proc_valid, guest_ctx, proc_ctx, is_global,
//          |                      | page_number, range_flag
// out      | out_valid / out_stall| cleared_count, valid_count
//
// A fill runs S_FILL, S_RESULT; an invalidation S_SCAN (one tag-memory read
// per entry, compared the cycle after), S_DRAIN, S_RESULT; unused op S_RESULT.
// One item is in work at a time; in_stall is high while it runs.
// The next item is taken while a result waits in the output register.
// Reset (rst, synchronous) clears all valid bits and the valid count at once.

module iotlb_invalidate_engine_core #(
  parameter int ENTRIES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      op,
  input  logic [3:0]                      entry_index,
  input  logic                            guest_valid,
  input  logic                            addr_valid,
  input  logic                            proc_valid,
  input  logic [iie_pkg::GCTX_W-1:0]      guest_ctx,
  input  logic [iie_pkg::PCTX_W-1:0]      proc_ctx,
  input  logic                            is_global,
  input  logic [iie_pkg::PAGE_W-1:0]      page_number,
  input  logic                            range_flag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [iie_pkg::COUNT_W-1:0]     cleared_count,
  output logic [iie_pkg::COUNT_W-1:0]     valid_count
);

  localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);

  iie_pkg::ctl_cmd_t cmd;
  iie_pkg::item_t item;
  logic [IW-1:0] rd_addr;

  assign item = '{op: op, entry_index: entry_index, guest_valid: guest_valid,
                  addr_valid: addr_valid, proc_valid: proc_valid,
                  guest_ctx: guest_ctx, proc_ctx: proc_ctx, is_global: is_global,
                  page: page_number, range_flag: range_flag};

  iie_ctrl #(
    .ENTRIES(ENTRIES),
    .IW(IW)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .op(op),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd(cmd),
    .rd_addr(rd_addr)
  );

  iie_datapath #(
    .ENTRIES(ENTRIES),
    .IW(IW),
    .CW(CW)
  ) u_datapath (
    .clk(clk),
    .rst(rst),
    .item(item),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .cleared_count(cleared_count),
    .valid_count(valid_count)
  );

endmodule
